[rtl/core/assert_macros.svh]
// assertion macros used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

[rtl/core/idba_pkg.sv]
// package: types and constants of the id bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
package idba_pkg;
	localparam logic [1:0] FUNC_ALLOC_ONE = 2'd0;
	localparam logic [1:0] FUNC_FREE_ONE = 2'd1;
	localparam logic [1:0] FUNC_ALLOC_AREA = 2'd2;
	localparam logic [1:0] FUNC_FREE_AREA = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic CFG_ID_BASE = 1'b0;
	localparam logic CFG_ID_COUNT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_SEARCH,
		S_MARK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] free_id;
		logic [10:0] run_length;
	} req_t;

	typedef struct packed {
		logic [31:0] granted_id;
		logic [1:0] status;
	} rsp_t;
endpackage
`default_nettype wire

[rtl/core/idba_if.sv]
// valid/ready channel interface
`timescale 1ns / 1ps
`default_nettype none
interface idba_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/idba_map.sv]
// bitmap memory, one bit per cycle read or write
`timescale 1ns / 1ps
`default_nettype none
module idba_map #(
	parameter int AW = 10
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] addr,
	input wire logic wdata,
	output logic rdata
);
	logic mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[rtl/core/id_bitmap_allocator.sv]
// id bitmap allocator: bit-serial next-fit search over a bitmap memory
// channels: req (func, free_id, run_length) in, rsp (granted_id, status) out,
// each a valid/ready pair; one response per request unless an id_count write intervenes.
// config: cfg_we/cfg_index/cfg_data; index 0 id_base, 1 id_count (clears the map).
// a search walks the bitmap bit by bit with a shared position counter and a
// run counter: each bit examined takes an address step, then a registered read
// step; an allocation may make two passes over id_count bits, then marks run_length.
// a free marks run_length bits; out-of-range requests go straight to the done state.
// after reset or an id_count write, a clearing pass over all MAX_IDS bits runs
// while no request is taken.
// the response is held in an output register until taken; a stalled receiver
// holds the block in its done state and no new request is accepted.
`timescale 1ns / 1ps
`default_nettype none
module id_bitmap_allocator
	import idba_pkg::*;
#(
	parameter int MAX_IDS = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	idba_if.sink req,
	idba_if.source rsp
);
	`include "assert_macros.svh"
	localparam int AW = $clog2(MAX_IDS);
	localparam int PW = AW + 1;

	state_t state_q, state_d;
	logic [31:0] base_q;
	logic [PW-1:0] count_q, start_q;
	logic [PW-1:0] pos_q, runst_q, run_q, len_q, end_q;
	logic second_q, rd_q, mark_val_q;
	logic [1:0] func_q;
	rsp_t rsp_q;
	logic [AW-1:0] maddr;
	logic mwe, mwd, mrd;
	req_t rq;
	logic [31:0] off;
	logic [11:0] n_req;
	logic [PW-1:0] cnt_new;
	logic is_free, rng_bad, len_bad, search_hit, search_miss;

	assign rq = req.data;
	assign off = rq.free_id - base_q;
	assign n_req = (rq.func == FUNC_ALLOC_ONE || rq.func == FUNC_FREE_ONE) ? 12'd1
		: {1'b0, rq.run_length};
	assign cnt_new = (cfg_data > 32'(MAX_IDS)) ? PW'(MAX_IDS) : PW'(cfg_data);
	assign is_free = (rq.func == FUNC_FREE_ONE || rq.func == FUNC_FREE_AREA);
	assign rng_bad = (off >= 32'(count_q)) || (33'(off) + 33'(n_req) > 33'(count_q));
	assign len_bad = (n_req == 12'd0) || (32'(n_req) > 32'(count_q));
	assign search_miss = !rd_q && (pos_q >= count_q) && second_q;
	assign search_hit = rd_q && !mrd && (run_q + 1'b1 == len_q);

	idba_map #(.AW(AW)) u_map (
		.clk(clk), .we(mwe), .addr(maddr), .wdata(mwd), .rdata(mrd)
	);

	assign req.ready = (state_q == S_IDLE) && !cfg_we;
	assign rsp.valid = (state_q == S_DONE);
	assign rsp.data = rsp_q;

	// memory port control
	always_comb begin
		mwe = 1'b0;
		mwd = 1'b0;
		maddr = pos_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mwe = 1'b1;
			end
			S_MARK: begin
				mwe = 1'b1;
				mwd = mark_val_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					if (is_free) begin
						state_d = (rng_bad || n_req == 12'd0) ? S_DONE : S_MARK;
					end else begin
						state_d = len_bad ? S_DONE : S_SEARCH;
					end
				end
			end
			S_CLEAR: if (pos_q == PW'(MAX_IDS - 1)) state_d = S_IDLE;
			S_SEARCH: begin
				if (search_miss) begin
					state_d = S_DONE;
				end else if (search_hit) begin
					state_d = S_MARK;
				end
			end
			S_MARK: if (pos_q == end_q - 1'b1) state_d = S_DONE;
			S_DONE: if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// an id_count write restarts the clearing pass
		if (cfg_we && cfg_index == CFG_ID_COUNT) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			base_q <= '0;
			count_q <= PW'(MAX_IDS);
			start_q <= '0;
			pos_q <= '0;
			rd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_ID_BASE) base_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_ID_COUNT) begin
				count_q <= cnt_new;
				start_q <= '0;
				pos_q <= '0;
			end else begin
				case (state_q)
					S_CLEAR: pos_q <= pos_q + 1'b1;
					S_IDLE: begin
						if (req.valid && req.ready) begin
							func_q <= rq.func;
							len_q <= PW'(n_req);
							second_q <= 1'b0;
							rd_q <= 1'b0;
							run_q <= '0;
							if (is_free) begin
								mark_val_q <= 1'b0;
								pos_q <= off[PW-1:0];
								runst_q <= off[PW-1:0];
								end_q <= off[PW-1:0] + PW'(n_req);
								rsp_q <= '{granted_id: '0,
									status: rng_bad ? ST_RANGE : ST_OK};
							end else begin
								mark_val_q <= 1'b1;
								pos_q <= start_q;
								runst_q <= start_q;
								if (len_bad) begin
									rsp_q <= '{granted_id: '0, status: ST_FULL};
								end
							end
						end
					end
					S_SEARCH: begin
						// per bit: an address step, then the registered read data
						if (!rd_q) begin
							if (pos_q >= count_q) begin
								if (second_q) begin
									rsp_q <= '{granted_id: '0, status: ST_FULL};
								end else begin
									second_q <= 1'b1;
									pos_q <= '0;
									runst_q <= '0;
									run_q <= '0;
								end
							end else begin
								rd_q <= 1'b1;
							end
						end else begin
							rd_q <= 1'b0;
							if (mrd) begin
								run_q <= '0;
								runst_q <= pos_q + 1'b1;
								pos_q <= pos_q + 1'b1;
							end else if (search_hit) begin
								rsp_q <= '{granted_id: base_q + 32'(runst_q), status: ST_OK};
								end_q <= pos_q + 1'b1;
								pos_q <= runst_q;
								start_q <= (func_q == FUNC_ALLOC_ONE) ? runst_q : pos_q + 1'b1;
							end else begin
								run_q <= run_q + 1'b1;
								pos_q <= pos_q + 1'b1;
							end
						end
					end
					S_MARK: pos_q <= pos_q + 1'b1;
					default: ;
				endcase
			end
		end
	end

	`ASSERT_IMPL(a_rsp_ok_zero, clk, arst_n, rsp.valid && rsp_q.status != ST_OK, rsp_q.granted_id == '0)
	`ASSERT_IMPL(a_start_range, clk, arst_n, state_q == S_IDLE, start_q <= count_q)
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp.ready && !cfg_we, rsp.valid && $stable(rsp_q))
endmodule
`default_nettype wire
